FILE: rtl/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue unit: widths, request codes,
// the per-cell control struct. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;
    localparam int OUT_W        = 72;

    // Request kinds carried on tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef logic signed [DATA_W-1:0] t_value;

    // Shift control shared by every cell of the chain
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } t_cell_ctl;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds a value, compares it with the
// incoming push value and trades data with both neighbors. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_value    i_item_value,
    input  logic      i_occupied,
    input  t_value    i_prev_value,
    input  logic      i_prev_stay,
    input  t_value    i_next_value,
    output t_value    o_value,
    output logic      o_stay
);

    t_value r_value;
    t_value n_value;

    // Keep own value on a push when it is stored and strictly larger
    assign o_stay = i_occupied && (r_value > i_item_value);

    // Pick the next value: hold, insert, shift down on push, shift up on pop
    always_comb begin
        n_value = r_value;
        if (i_ctl.push_en) begin
            if (o_stay) begin
                n_value = r_value;
            end else if (i_prev_stay) begin
                n_value = i_item_value;
            end else begin
                n_value = i_prev_value;
            end
        end else if (i_ctl.pop_en) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue unit, largest value at the head.
// Channels: slave side takes one request per beat; tuser[0] is the kind
// (0 push, 1 pop), tdata[31:0] the signed value to push (ignored on pop).
// Master side returns one result beat per request, tdata fields from bit 0:
// head_value[31:0], head_valid[32], occupancy[37:33], removed_value[69:38],
// removed_valid[70], overflow[71].
// The result beat is registered and valid in the cycle after the request beat.
// One request per cycle while the receiver is ready; every cell of the chain
// compares its value with the pushed one and shifts in the same cycle.
// A push into a full queue is dropped and flagged as overflow; a pop on an
// empty queue changes nothing and reports removed_valid low.
// Reset empties the queue (occupancy zero) and drops any waiting result beat;
// slot contents are not cleared, empty slots are never read.
// When the receiver stalls, the result is held and o_s_tready drops until
// the waiting beat is taken; a beat can be taken and a new request
// accepted in the same cycle.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_assert.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,  // item_value[31:0]
    input  logic [0:0]       i_s_tuser,   // req_type[0]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // head_value[31:0], head_valid[32], occupancy[37:33],
    // removed_value[69:38], removed_valid[70], overflow[71]
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = CNT_W + OCC_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_m_valid;
    t_value           r_head_value;
    logic             r_head_valid;
    logic [OCC_W-1:0] r_occupancy;
    t_value           r_removed_value;
    logic             r_removed_valid;
    logic             r_overflow;

    logic             w_accept;
    logic             w_is_pop;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    t_value           w_item;
    t_value           w_value [CAPACITY];
    logic             w_stay  [CAPACITY];
    logic             w_occ   [CAPACITY];
    t_value           w_prev  [CAPACITY];
    logic             w_pstay [CAPACITY];
    t_value           w_next  [CAPACITY];
    t_value           w_head_after;
    logic [EXT_W-1:0] w_cnt_ext;

    // Accept while the result register is free or being drained
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_pop   = (i_s_tuser[0] == REQ_POP);
    assign w_item     = t_value'(i_s_tdata);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_ctl.push_en = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop_en  = w_accept && w_is_pop && !w_empty;

    // Build the chain: neighbor wiring and occupied flags per slot
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign w_occ[i] = (CNT_W'(i) < r_count);
        if (i == 0) begin : g_first
            assign w_prev[i]  = w_value[i];
            assign w_pstay[i] = 1'b1;
        end else begin : g_mid
            assign w_prev[i]  = w_value[i-1];
            assign w_pstay[i] = w_stay[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_next[i] = w_value[i];
        end else begin : g_inner
            assign w_next[i] = w_value[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_item_value (w_item),
            .i_occupied   (w_occ[i]),
            .i_prev_value (w_prev[i]),
            .i_prev_stay  (w_pstay[i]),
            .i_next_value (w_next[i]),
            .o_value      (w_value[i]),
            .o_stay       (w_stay[i])
        );
    end

    // Advance the fill count
    always_comb begin
        n_count = r_count;
        if (w_ctl.push_en) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.pop_en) begin
            n_count = r_count - 1'b1;
        end
    end

    // Head after this request, before masking for an empty queue
    always_comb begin
        w_head_after = w_value[0];
        if (w_ctl.push_en) begin
            w_head_after = w_stay[0] ? w_value[0] : w_item;
        end else if (w_ctl.pop_en) begin
            w_head_after = w_value[1];
        end
    end

    assign w_cnt_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head_value    <= (n_count != '0) ? w_head_after : '0;
            r_head_valid    <= (n_count != '0);
            r_occupancy     <= w_cnt_ext[OCC_W-1:0];
            r_removed_value <= w_ctl.pop_en ? w_value[0] : '0;
            r_removed_valid <= w_ctl.pop_en;
            r_overflow      <= w_accept && !w_is_pop && w_full;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_overflow, r_removed_valid, r_removed_value,
                         r_occupancy, r_head_valid, r_head_value};

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count past capacity")
    `SPQ_ASSERT_NOW(a_ovf_full, r_m_valid && r_overflow, r_count == CNT_W'(CAPACITY) && !r_removed_valid, "overflow without full queue")
    `SPQ_ASSERT_NOW(a_head_valid, r_m_valid, r_head_valid == (r_count != '0), "head flag disagrees with count")
    `SPQ_ASSERT_NEXT(a_pop_dec, w_accept && w_is_pop && !w_empty, r_count == $past(r_count) - 1'b1, "pop did not drop count")

endmodule

FILE: tb/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for sorted_priority_queue_unit: a stream driver and
// a result monitor with an in-bench sorted-list predictor.
// Depends on spq_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int NUM_RANDOM    = 550;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 10;

    // One pending request beat, or a marker that pauses the sender until drained
    typedef struct {
        logic   req;
        t_value value;
        logic   drain;
    } t_request;

    // One result beat, split into its fields
    typedef struct {
        t_value            head_value;
        logic              head_valid;
        logic [OCC_W-1:0]  occupancy;
        t_value            removed_value;
        logic              removed_valid;
        logic              overflow;
    } t_queue_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;   // item_value[31:0]
    logic [0:0]        i_s_tuser = '0;   // req_type[0]
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    // head_value[31:0], head_valid[32], occupancy[37:33],
    // removed_value[69:38], removed_valid[70], overflow[71]
    logic [OUT_W-1:0]  o_m_tdata;

    t_request      pending_reqs[$];
    t_queue_result expected_results[$];
    t_value        sorted_vals[SPQ_CAPACITY];
    int            stored_count = 0;
    int            error_count = 0;
    int            results_seen = 0;
    int            cycle_count = 0;

    sorted_priority_queue_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the sorted list and return the result it causes
    function automatic t_queue_result apply_request(logic req, t_value value);
        t_queue_result res;
        int pos;
        res.removed_value = '0;
        res.removed_valid = 1'b0;
        res.overflow      = 1'b0;
        if (req == REQ_PUSH) begin
            if (stored_count >= SPQ_CAPACITY) begin
                res.overflow = 1'b1;
            end else begin
                // place ahead of equal values, behind larger ones
                pos = 0;
                while (pos < stored_count && sorted_vals[pos] > value)
                    pos++;
                for (int i = stored_count; i > pos; i--)
                    sorted_vals[i] = sorted_vals[i-1];
                sorted_vals[pos] = value;
                stored_count++;
            end
        end else if (stored_count > 0) begin
            res.removed_value = sorted_vals[0];
            res.removed_valid = 1'b1;
            for (int i = 1; i < stored_count; i++)
                sorted_vals[i-1] = sorted_vals[i];
            stored_count--;
        end
        res.head_value = (stored_count > 0) ? sorted_vals[0] : '0;
        res.head_valid = (stored_count > 0);
        res.occupancy  = OCC_W'(stored_count);
        return res;
    endfunction

    task automatic add_push(t_value value);
        pending_reqs.push_back('{req: REQ_PUSH, value: value, drain: 1'b0});
    endtask

    task automatic add_pop();
        // the value lane is ignored on a pop, so keep it noisy
        pending_reqs.push_back('{req: REQ_POP, value: t_value'($urandom), drain: 1'b0});
    endtask

    task automatic add_drain();
        pending_reqs.push_back('{req: REQ_PUSH, value: '0, drain: 1'b1});
    endtask

    // Mix of extremes, a narrow band that forces ties, and full-range values
    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 4))
                0: return t_value'(32'h7fff_ffff);
                1: return t_value'(32'h8000_0000);
                2: return t_value'(0);
                3: return t_value'(-1);
                default: return t_value'(1);
            endcase
        end else if (sel <= 3) begin
            return t_value'(int'($urandom_range(0, 15)) - 8);
        end
        return t_value'($urandom);
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Driver: present the front of the request queue in bursts with gaps
    always @(posedge i_clk) begin : drive_proc
        logic fire;
        int   burst_left;
        int   gap_left;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            fire = i_s_tvalid && o_s_tready;
            if (fire) begin
                expected_results.push_back(apply_request(pending_reqs[0].req,
                                                         pending_reqs[0].value));
                void'(pending_reqs.pop_front());
            end
            if (i_s_tvalid && !fire) begin
                // hold the beat until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && pending_reqs[0].drain) begin
                // pause until every result is back
                i_s_tvalid <= 1'b0;
                if (expected_results.size() == 0)
                    void'(pending_reqs.pop_front());
            end else if (pending_reqs.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_reqs[0].value;
                i_s_tuser  <= pending_reqs[0].req;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off
    always @(posedge i_clk) begin : ready_proc
        int  rx_cycle;
        int  hold_left;
        int  stall_mode;
        bit  hold_done;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_cycle   = 0;
            hold_left  = 0;
            stall_mode = 0;
            hold_done  = 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= ($urandom_range(0, 1) == 1);
                    2: i_m_tready <= ($urandom_range(0, 7) != 0);
                    default: i_m_tready <= ((rx_cycle % 5) != 0);
                endcase
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : monitor_proc
        t_queue_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding: 0x%018h", o_m_tdata);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("head_value", exp_res.head_value, o_m_tdata[31:0]);
                check_field("head_valid", 32'(exp_res.head_valid), 32'(o_m_tdata[32]));
                check_field("occupancy", 32'(exp_res.occupancy), 32'(o_m_tdata[37:33]));
                check_field("removed_value", exp_res.removed_value, o_m_tdata[69:38]);
                check_field("removed_valid", 32'(exp_res.removed_valid),
                            32'(o_m_tdata[70]));
                check_field("overflow", 32'(exp_res.overflow), 32'(o_m_tdata[71]));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : stim_proc
        int push_pct;
        int phase_len;
        int n_random;
        bit drained_mid;
        // directed: pop on empty, extremes, ties with head and inside, fill up
        add_pop();
        add_push(t_value'(32'h7fff_ffff));
        add_push(t_value'(32'h8000_0000));
        add_push(t_value'(0));
        add_push(t_value'(-1));
        add_push(t_value'(1));
        add_push(t_value'(1));
        add_push(t_value'(32'h7fff_ffff));
        for (int i = 0; i < 9; i++)
            add_push(t_value'($urandom));
        add_push(t_value'(5));        // full: dropped
        add_pop();                    // take the maximum
        add_pop();                    // tie with the old head
        add_push(t_value'(32'h8000_0000));
        add_drain();

        // random: push-heavy and pop-heavy phases walk the fill level end to end
        n_random    = 0;
        drained_mid = 1'b0;
        while (n_random < NUM_RANDOM) begin
            case ($urandom_range(0, 4))
                0: push_pct = 90;
                1: push_pct = 10;
                2: push_pct = 50;
                3: push_pct = 70;
                default: push_pct = 30;
            endcase
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 99) < push_pct)
                    add_push(pick_value());
                else
                    add_pop();
                n_random++;
            end
            if (!drained_mid && n_random >= NUM_RANDOM / 2) begin
                drained_mid = 1'b1;
                add_drain();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (expected_results.size() > 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
